FILE: sv/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg: first-fit block allocator shared definitions
// Sizes, the block table entry, status codes and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int HEAP_BYTES   = 65536;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int OFF_W  = 16;
    localparam int SIZE_W = 17;
    localparam int REQ_W  = 16;
    localparam int LIM_W  = 17;
    localparam int TOP_W  = 17;

    localparam logic [LIM_W-1:0] LIMIT_RST = LIM_W'(65536);
    // arena bound clipped to what the limit register can express
    localparam logic [LIM_W-1:0] HEAP_CAP  =
        (HEAP_BYTES < 2 ** LIM_W) ? LIM_W'(HEAP_BYTES) : LIM_W'(2 ** LIM_W - 1);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NULL    = 2'd1,
        ST_NOMEM   = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  off;
    } t_entry;

    typedef enum logic [1:0] {
        RD_SCAN = 2'd0,
        RD_NEXT = 2'd1,
        RD_UP   = 2'd2,
        RD_DN   = 2'd3
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_SHIFT      = 3'd0,
        WR_SPLIT      = 3'd1,
        WR_TAKE       = 3'd2,
        WR_TAKE_SPLIT = 3'd3,
        WR_MERGE      = 3'd4,
        WR_FREE       = 3'd5,
        WR_APPEND     = 3'd6
    } t_wr_sel;

    typedef enum logic [1:0] {
        PAY_ZERO = 2'd0,
        PAY_HIT  = 2'd1,
        PAY_TOP  = 2'd2
    } t_pay_sel;

    typedef struct packed {
        logic     load;
        logic     scan_clr;
        logic     scan;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_sel  wr_sel;
        logic     k_up_init;
        logic     k_dn_init;
        logic     k_dec;
        logic     k_inc;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     top_add;
        logic     res_set;
        t_status  res_code;
        t_pay_sel pay_sel;
        logic     res_out;
    } t_cmd;

    typedef struct packed {
        logic is_rel;
        logic zero_req;
        logic null_addr;
        logic hit;
        logic scan_end;
        logic can_split;
        logic full;
        logic overflow;
        logic has_next;
        logic next_free;
        logic up_done;
        logic dn_done;
        logic out_free;
    } t_stat;

endpackage

FILE: sv/ffba_if.sv
// ----------------------------------------------------------------------------
// ffba_if: request and result channels of the block allocator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ffba_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] size;
    logic [15:0] addr;

    modport source (output valid, output op, output size, output addr, input ready);
    modport sink   (input valid, input op, input size, input addr, output ready);
endinterface

interface ffba_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] payload;

    modport source (output valid, output status, output payload, input ready);
    modport sink   (input valid, input status, input payload, output ready);
endinterface

FILE: sv/first_fit_block_allocator.sv
// Throughput: one request at a time; the block table, with one write and one
//   registered read port, sets the pace (one entry read per scan cycle, one read
//   and one write per shifted entry).
// Reset (synchronous, active low): table empty, heap top 0, limit 65536.
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit heap block allocator
// Allocates and releases arena blocks kept in an address-ordered table.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [16:0]  i_cfg_wdata,
    ffba_req_if.sink     i_in,
    ffba_res_if.source   o_out
);

    ffba_pkg::t_cmd  cmd;
    ffba_pkg::t_stat stat;
    logic            in_ready;

    assign i_in.ready = in_ready;

    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ffba_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (i_in.op),
        .i_size      (i_in.size),
        .i_addr      (i_in.addr),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_status    (o_out.status),
        .o_payload   (o_out.payload)
    );

endmodule

FILE: sv/ffba_dpath.sv
// ----------------------------------------------------------------------------
// ffba_dpath: block table datapath
// Holds the block table memory, the scan and shift pointers, the heap top,
// the limit register and the result registers. Driven by ffba_ctrl.
// ----------------------------------------------------------------------------
module ffba_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffba_pkg::t_cmd        i_cmd,
    output ffba_pkg::t_stat       o_stat,
    input  logic                  i_cfg_we,
    input  logic [16:0]           i_cfg_wdata,
    input  logic                  i_op,
    input  logic [15:0]           i_size,
    input  logic [15:0]           i_addr,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [15:0]           o_payload
);

    localparam int IW = ffba_pkg::IDX_W;
    localparam int CW = ffba_pkg::CNT_W;

    // block table
    ffba_pkg::t_entry r_mem [ffba_pkg::MAX_BLOCKS];
    ffba_pkg::t_entry r_rd;
    logic             r_rd_vld;
    logic [IW-1:0]    r_rd_at;

    logic [CW-1:0]    r_idx, r_k, r_cnt;
    logic [IW-1:0]    r_hit;
    ffba_pkg::t_entry r_cur;
    logic [ffba_pkg::TOP_W-1:0] r_top;
    logic [ffba_pkg::LIM_W-1:0] r_limit;
    logic                       r_op;
    logic [ffba_pkg::REQ_W-1:0] r_size;
    logic [15:0]                r_addr;
    ffba_pkg::t_status          r_pend_status;
    logic [15:0]                r_pend_pay;
    logic                       r_ov;
    logic [1:0]                 r_ostatus;
    logic [15:0]                r_opay;

    logic [CW-1:0]    hit_p1, k_m1, k_p1;
    logic [IW-1:0]    rd_addr, wr_addr;
    ffba_pkg::t_entry wr_data;
    logic             scan_issue, rd_go, match;
    logic [ffba_pkg::LIM_W-1:0]  bound;
    logic [ffba_pkg::TOP_W-1:0]  need;
    logic [ffba_pkg::OFF_W-1:0]  new_off;
    logic [ffba_pkg::SIZE_W-1:0] rest, merged;
    logic [15:0]                 pay;

    assign hit_p1 = CW'({1'b0, r_hit}) + CW'(1);
    assign k_m1   = r_k - CW'(1);
    assign k_p1   = r_k + CW'(1);

    // read address select
    always_comb begin
        unique case (i_cmd.rd_sel)
            ffba_pkg::RD_SCAN: rd_addr = r_idx[IW-1:0];
            ffba_pkg::RD_NEXT: rd_addr = hit_p1[IW-1:0];
            ffba_pkg::RD_UP:   rd_addr = k_m1[IW-1:0];
            ffba_pkg::RD_DN:   rd_addr = k_p1[IW-1:0];
            default:           rd_addr = r_idx[IW-1:0];
        endcase
    end

    assign scan_issue = i_cmd.scan && (r_idx < r_cnt);
    assign rd_go      = scan_issue || i_cmd.rd_en;

    // candidate test on the entry read last cycle
    always_comb begin
        if (r_op == ffba_pkg::OP_ALLOC) begin
            match = r_rd.free && (r_rd.size >= {1'b0, r_size});
        end else begin
            match = ({1'b0, r_rd.off} + 17'(ffba_pkg::HEADER_BYTES)) == {1'b0, r_addr};
        end
    end

    // heap growth bound
    assign bound = (r_limit < ffba_pkg::HEAP_CAP) ? r_limit : ffba_pkg::HEAP_CAP;
    assign need  = ffba_pkg::TOP_W'(r_size) + ffba_pkg::TOP_W'(ffba_pkg::HEADER_BYTES);

    // split and merge arithmetic
    assign new_off = r_cur.off + ffba_pkg::OFF_W'(ffba_pkg::HEADER_BYTES) + r_size;
    assign rest    = r_cur.size - ffba_pkg::SIZE_W'(r_size)
                     - ffba_pkg::SIZE_W'(ffba_pkg::HEADER_BYTES);
    assign merged  = r_cur.size + ffba_pkg::SIZE_W'(ffba_pkg::HEADER_BYTES) + r_rd.size;

    // status toward the controller
    always_comb begin
        o_stat.is_rel    = (r_op == ffba_pkg::OP_RELEASE);
        o_stat.zero_req  = (r_size == '0);
        o_stat.null_addr = (r_addr == '0);
        o_stat.hit       = r_rd_vld && match;
        o_stat.scan_end  = !r_rd_vld && (r_idx >= r_cnt);
        o_stat.full      = (r_cnt >= CW'(ffba_pkg::MAX_BLOCKS));
        o_stat.can_split = ({1'b0, r_cur.size} >= (18'(r_size)
                            + 18'(ffba_pkg::HEADER_BYTES + 1)))
                           && !(r_cnt >= CW'(ffba_pkg::MAX_BLOCKS));
        o_stat.overflow  = (r_top > bound) || (need > (bound - r_top));
        o_stat.has_next  = hit_p1 < r_cnt;
        o_stat.next_free = r_rd.free;
        o_stat.up_done   = r_k <= hit_p1;
        o_stat.dn_done   = ({1'b0, r_k} + (CW+1)'(1)) >= {1'b0, r_cnt};
        o_stat.out_free  = !r_ov || i_out_ready;
    end

    // write address and data
    always_comb begin
        unique case (i_cmd.wr_sel)
            ffba_pkg::WR_SHIFT: begin
                wr_addr = r_k[IW-1:0];
                wr_data = r_rd;
            end
            ffba_pkg::WR_SPLIT: begin
                wr_addr = hit_p1[IW-1:0];
                wr_data = '{free: 1'b1, size: rest, off: new_off};
            end
            ffba_pkg::WR_TAKE: begin
                wr_addr = r_hit;
                wr_data = '{free: 1'b0, size: r_cur.size, off: r_cur.off};
            end
            ffba_pkg::WR_TAKE_SPLIT: begin
                wr_addr = r_hit;
                wr_data = '{free: 1'b0, size: ffba_pkg::SIZE_W'(r_size), off: r_cur.off};
            end
            ffba_pkg::WR_MERGE: begin
                wr_addr = r_hit;
                wr_data = '{free: 1'b1, size: merged, off: r_cur.off};
            end
            ffba_pkg::WR_FREE: begin
                wr_addr = r_hit;
                wr_data = '{free: 1'b1, size: r_cur.size, off: r_cur.off};
            end
            ffba_pkg::WR_APPEND: begin
                wr_addr = r_cnt[IW-1:0];
                wr_data = '{free: 1'b0, size: ffba_pkg::SIZE_W'(r_size),
                            off: r_top[ffba_pkg::OFF_W-1:0]};
            end
            default: begin
                wr_addr = r_hit;
                wr_data = r_cur;
            end
        endcase
    end

    // table memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_go) begin
            r_rd    <= r_mem[rd_addr];
            r_rd_at <= rd_addr;
        end
    end

    // result payload select
    always_comb begin
        unique case (i_cmd.pay_sel)
            ffba_pkg::PAY_HIT: pay = r_cur.off + 16'(ffba_pkg::HEADER_BYTES);
            ffba_pkg::PAY_TOP: pay = r_top[15:0] + 16'(ffba_pkg::HEADER_BYTES);
            default:           pay = '0;
        endcase
    end

    // request, scan, shift pointer and result registers (no reset)
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_size <= i_size;
            r_addr <= i_addr;
        end
        if (i_cmd.scan_clr) begin
            r_idx <= '0;
        end else if (scan_issue) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.scan && r_rd_vld && match) begin
            r_hit <= r_rd_at;
            r_cur <= r_rd;
        end
        if (i_cmd.k_up_init) begin
            r_k <= r_cnt;
        end else if (i_cmd.k_dn_init) begin
            r_k <= hit_p1;
        end else if (i_cmd.k_dec) begin
            r_k <= k_m1;
        end else if (i_cmd.k_inc) begin
            r_k <= k_p1;
        end
        if (i_cmd.res_set) begin
            r_pend_status <= i_cmd.res_code;
            r_pend_pay    <= pay;
        end
        if (i_cmd.res_out) begin
            r_ostatus <= r_pend_status;
            r_opay    <= r_pend_pay;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_top    <= '0;
            r_limit  <= ffba_pkg::LIMIT_RST;
            r_ov     <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.top_add) begin
                r_top <= r_top + need;
            end
            r_rd_vld <= i_cmd.scan_clr ? 1'b0 : rd_go;
            if (i_cmd.res_out) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_status    = r_ostatus;
    assign o_payload   = r_opay;

endmodule

FILE: sv/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl: block allocator sequencer
// Steps each request through table scan, split/merge shifting, heap growth
// and result hand-off by commands to ffba_dpath.
// ----------------------------------------------------------------------------
module ffba_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ffba_pkg::t_stat i_stat,
    output ffba_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_AHIT,
        S_UP_RD,
        S_UP_WR,
        S_SPLIT_NEW,
        S_TAKE_SPLIT,
        S_MISS,
        S_RHIT,
        S_RNEXT,
        S_DN_RD,
        S_DN_WR,
        S_RES
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if ((!i_stat.is_rel && i_stat.zero_req) || (i_stat.is_rel && i_stat.null_addr)) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ffba_pkg::ST_NULL;
                    n_state        = S_RES;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit) begin
                    n_state = i_stat.is_rel ? S_RHIT : S_AHIT;
                end else if (i_stat.scan_end) begin
                    if (i_stat.is_rel) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = ffba_pkg::ST_UNKNOWN;
                        n_state        = S_RES;
                    end else begin
                        n_state = S_MISS;
                    end
                end
            end
            S_AHIT: begin
                if (i_stat.can_split) begin
                    o_cmd.k_up_init = 1'b1;
                    n_state         = S_UP_RD;
                end else begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_sel   = ffba_pkg::WR_TAKE;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ffba_pkg::ST_OK;
                    o_cmd.pay_sel  = ffba_pkg::PAY_HIT;
                    n_state        = S_RES;
                end
            end
            // open a slot after the hit, top entry first
            S_UP_RD: begin
                if (i_stat.up_done) begin
                    n_state = S_SPLIT_NEW;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ffba_pkg::RD_UP;
                    n_state      = S_UP_WR;
                end
            end
            S_UP_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = ffba_pkg::WR_SHIFT;
                o_cmd.k_dec  = 1'b1;
                n_state      = S_UP_RD;
            end
            S_SPLIT_NEW: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = ffba_pkg::WR_SPLIT;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_TAKE_SPLIT;
            end
            S_TAKE_SPLIT: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_sel   = ffba_pkg::WR_TAKE_SPLIT;
                o_cmd.res_set  = 1'b1;
                o_cmd.res_code = ffba_pkg::ST_OK;
                o_cmd.pay_sel  = ffba_pkg::PAY_HIT;
                n_state        = S_RES;
            end
            // grow from the heap top, or report no memory when the table is full or the bound is passed
            S_MISS: begin
                o_cmd.res_set = 1'b1;
                n_state       = S_RES;
                if (i_stat.full || i_stat.overflow) begin
                    o_cmd.res_code = ffba_pkg::ST_NOMEM;
                end else begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_sel   = ffba_pkg::WR_APPEND;
                    o_cmd.cnt_inc  = 1'b1;
                    o_cmd.top_add  = 1'b1;
                    o_cmd.res_code = ffba_pkg::ST_OK;
                    o_cmd.pay_sel  = ffba_pkg::PAY_TOP;
                end
            end
            S_RHIT: begin
                if (i_stat.has_next) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ffba_pkg::RD_NEXT;
                    n_state      = S_RNEXT;
                end else begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_sel   = ffba_pkg::WR_FREE;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ffba_pkg::ST_OK;
                    n_state        = S_RES;
                end
            end
            S_RNEXT: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.next_free) begin
                    o_cmd.wr_sel    = ffba_pkg::WR_MERGE;
                    o_cmd.k_dn_init = 1'b1;
                    n_state         = S_DN_RD;
                end else begin
                    o_cmd.wr_sel   = ffba_pkg::WR_FREE;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ffba_pkg::ST_OK;
                    n_state        = S_RES;
                end
            end
            // close the merged slot, bottom entry first
            S_DN_RD: begin
                if (i_stat.dn_done) begin
                    o_cmd.cnt_dec  = 1'b1;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ffba_pkg::ST_OK;
                    n_state        = S_RES;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ffba_pkg::RD_DN;
                    n_state      = S_DN_WR;
                end
            end
            S_DN_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = ffba_pkg::WR_SHIFT;
                o_cmd.k_inc  = 1'b1;
                n_state      = S_DN_RD;
            end
            S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.res_out = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/ffba_chk.sv
// ----------------------------------------------------------------------------
// ffba_chk: port-level checks for the block allocator
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module ffba_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_status,
    input logic [15:0] i_out_payload
);

    // a result beat holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload)
        && $stable(i_out_status))
        else $error("result beat changed while stalled");

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a nonzero payload is a successful allocation past the header
    a_pay_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_payload != 16'd0) |->
        (i_out_status == ffba_pkg::ST_OK)
        && (i_out_payload >= 16'(ffba_pkg::HEADER_BYTES)))
        else $error("nonzero payload on failure or below header");

    // a request is never accepted in the cycle after another was accepted
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted on back-to-back cycles");

endmodule

bind first_fit_block_allocator ffba_chk u_ffba_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_status  (o_out.status),
    .i_out_payload (o_out.payload)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for first_fit_block_allocator
// Drives allocate and release beats through the request channel, predicts
// every result with a local copy of the block table, heap top and limit,
// and compares each result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 300;
    localparam int MAX_SHOWN      = 10;

    typedef struct {
        ffba_pkg::t_status status;
        logic [15:0]       payload;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [16:0] i_cfg_wdata;

    ffba_req_if req ();
    ffba_res_if res ();

    first_fit_block_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (req.sink),
        .o_out       (res.source)
    );

    // predicted allocator state
    int  blk_off  [ffba_pkg::MAX_BLOCKS];
    int  blk_size [ffba_pkg::MAX_BLOCKS];
    bit  blk_free [ffba_pkg::MAX_BLOCKS];
    int  blk_count;
    int  arena_top;
    int  arena_limit;

    t_result pending_results[$];
    int  mismatches;
    int  idle_cycles;
    bit  idling_on;
    bit  hold_request;

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // allocate: first fit, split when the rest holds a header plus a byte and the table has room
    function automatic t_result predict_alloc(int want);
        t_result r;
        int i;
        int k;
        int bound;
        r.status  = ffba_pkg::ST_NOMEM;
        r.payload = '0;
        if (want == 0) begin
            r.status = ffba_pkg::ST_NULL;
            return r;
        end
        for (i = 0; i < blk_count; i++) begin
            if (blk_free[i] && blk_size[i] >= want) begin
                if (blk_size[i] >= want + ffba_pkg::HEADER_BYTES + 1 &&
                    blk_count < ffba_pkg::MAX_BLOCKS) begin
                    for (k = blk_count; k > i + 1; k--) begin
                        blk_off[k]  = blk_off[k-1];
                        blk_size[k] = blk_size[k-1];
                        blk_free[k] = blk_free[k-1];
                    end
                    blk_count++;
                    blk_off[i+1]  = blk_off[i] + ffba_pkg::HEADER_BYTES + want;
                    blk_size[i+1] = blk_size[i] - want - ffba_pkg::HEADER_BYTES;
                    blk_free[i+1] = 1'b1;
                    blk_size[i]   = want;
                end
                blk_free[i] = 1'b0;
                r.status  = ffba_pkg::ST_OK;
                r.payload = 16'(blk_off[i] + ffba_pkg::HEADER_BYTES);
                return r;
            end
        end
        if (blk_count >= ffba_pkg::MAX_BLOCKS) return r;
        bound = (arena_limit < ffba_pkg::HEAP_BYTES) ? arena_limit : ffba_pkg::HEAP_BYTES;
        if (arena_top > bound || ffba_pkg::HEADER_BYTES + want > bound - arena_top) return r;
        blk_off[blk_count]  = arena_top;
        blk_size[blk_count] = want;
        blk_free[blk_count] = 1'b0;
        blk_count++;
        arena_top += ffba_pkg::HEADER_BYTES + want;
        r.status  = ffba_pkg::ST_OK;
        r.payload = 16'(blk_off[blk_count-1] + ffba_pkg::HEADER_BYTES);
        return r;
    endfunction

    // release: mark free, merge only with a free next block
    function automatic t_result predict_release(int where);
        t_result r;
        int i;
        int k;
        r.status  = ffba_pkg::ST_OK;
        r.payload = '0;
        if (where == 0) begin
            r.status = ffba_pkg::ST_NULL;
            return r;
        end
        for (i = 0; i < blk_count; i++)
            if (blk_off[i] + ffba_pkg::HEADER_BYTES == where) break;
        if (i >= blk_count) begin
            r.status = ffba_pkg::ST_UNKNOWN;
            return r;
        end
        blk_free[i] = 1'b1;
        if (i + 1 < blk_count && blk_free[i+1]) begin
            blk_size[i] = blk_size[i] + ffba_pkg::HEADER_BYTES + blk_size[i+1];
            for (k = i + 1; k + 1 < blk_count; k++) begin
                blk_off[k]  = blk_off[k+1];
                blk_size[k] = blk_size[k+1];
                blk_free[k] = blk_free[k+1];
            end
            blk_count--;
        end
        return r;
    endfunction

    // request beat accepted: predict its result
    always @(posedge i_clk) begin
        if (i_rst_n && req.valid && req.ready) begin
            if (req.op == ffba_pkg::OP_ALLOC)
                pending_results.push_back(predict_alloc(int'(req.size)));
            else
                pending_results.push_back(predict_release(int'(req.addr)));
        end
    end

    // result beat accepted: compare with the oldest prediction
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("tb_top: unexpected result status=%0d payload=%0d",
                             res.status, res.payload);
            end else begin
                exp_r = pending_results.pop_front();
                if (res.status !== exp_r.status || res.payload !== exp_r.payload) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("tb_top: mismatch exp status=%0d payload=%0d, got %0d %0d",
                                 exp_r.status, exp_r.payload, res.status, res.payload);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // result receiver: random stall bursts and the long hold-off
    initial begin
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                res.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                res.ready = 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
            end else begin
                res.ready = 1'b1;
            end
        end
    end

    // send one request beat, with an occasional gap ahead of it
    task automatic send_req(ffba_pkg::t_op op, logic [15:0] size, logic [15:0] addr);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            req.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        req.op    = op;
        req.size  = size;
        req.addr  = addr;
        req.valid = 1'b1;
        do @(posedge i_clk); while (!req.ready);
        @(negedge i_clk);
        req.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [16:0] value);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        arena_limit = int'(value);
    endtask

    // payload of a random live table entry, or 0 when the table is empty
    function automatic logic [15:0] known_addr();
        if (blk_count == 0) return '0;
        return 16'(blk_off[$urandom_range(0, blk_count - 1)] + ffba_pkg::HEADER_BYTES);
    endfunction

    task automatic test_directed();
        send_req(ffba_pkg::OP_ALLOC, 16'd0, 16'hFFFF);      // zero size
        send_req(ffba_pkg::OP_RELEASE, 16'hFFFF, 16'd0);    // null release
        send_req(ffba_pkg::OP_RELEASE, 16'd0, 16'd5);       // unknown address
        send_req(ffba_pkg::OP_ALLOC, 16'd1, 16'd0);
        send_req(ffba_pkg::OP_ALLOC, 16'd100, 16'd0);
        send_req(ffba_pkg::OP_ALLOC, 16'd7, 16'd0);
        send_req(ffba_pkg::OP_ALLOC, 16'hFFFF, 16'd0);      // heap overflow
        send_req(ffba_pkg::OP_RELEASE, 16'd0, 16'd49);      // second block, next in use
        send_req(ffba_pkg::OP_RELEASE, 16'd0, 16'd24);      // first block merges
        send_req(ffba_pkg::OP_RELEASE, 16'd0, 16'd24);      // double release
        send_req(ffba_pkg::OP_ALLOC, 16'd10, 16'd0);        // split of the merged block
        send_req(ffba_pkg::OP_ALLOC, 16'd90, 16'd0);        // remainder taken unsplit, one byte larger than asked
        send_req(ffba_pkg::OP_RELEASE, 16'd0, 16'hFFFF);    // unknown, all ones
        send_req(ffba_pkg::OP_RELEASE, 16'd0, 16'd50);      // off by one
    endtask

    task automatic test_limits();
        write_limit(17'd0);
        send_req(ffba_pkg::OP_ALLOC, 16'd1, 16'd0);
        send_req(ffba_pkg::OP_ALLOC, 16'd500, 16'd0);
        write_limit(17'(arena_top + 2 * ffba_pkg::HEADER_BYTES + 2));
        send_req(ffba_pkg::OP_ALLOC, 16'd2, 16'd0);         // leaves 24 bytes below the bound
        send_req(ffba_pkg::OP_ALLOC, 16'd1, 16'd0);         // one byte more than what is left
        write_limit(17'h1FFFF);                             // above the arena: clipped
        send_req(ffba_pkg::OP_ALLOC, 16'hFFFF, 16'd0);
        send_req(ffba_pkg::OP_ALLOC,
                 16'(ffba_pkg::HEAP_BYTES - ffba_pkg::HEADER_BYTES - arena_top), 16'd0);
        // hand the last block back so later tests can split it
        send_req(ffba_pkg::OP_RELEASE, 16'd0,
                 16'(blk_off[blk_count-1] + ffba_pkg::HEADER_BYTES));
        write_limit(ffba_pkg::LIMIT_RST);
    endtask

    task automatic test_table_full();
        int guard;
        guard = 0;
        while (blk_count < ffba_pkg::MAX_BLOCKS - 1 && guard < 300) begin
            send_req(ffba_pkg::OP_ALLOC, 16'd1, 16'd0);
            guard++;
        end
        send_req(ffba_pkg::OP_ALLOC, 16'd300, 16'd0);
        while (blk_count < ffba_pkg::MAX_BLOCKS && guard < 400) begin
            send_req(ffba_pkg::OP_ALLOC, 16'd1, 16'd0);
            guard++;
        end
        send_req(ffba_pkg::OP_ALLOC, 16'd1, 16'd0);         // rest taken unsplit
        send_req(ffba_pkg::OP_ALLOC, 16'd1, 16'd0);         // table full on growth
        // free a big block and reuse it while the table is full
        for (int j = 0; j < blk_count; j++) begin
            if (blk_size[j] >= 300 && !blk_free[j] &&
                (j + 1 == blk_count || !blk_free[j+1])) begin
                send_req(ffba_pkg::OP_RELEASE, 16'd0,
                         16'(blk_off[j] + ffba_pkg::HEADER_BYTES));
                break;
            end
        end
        send_req(ffba_pkg::OP_ALLOC, 16'd10, 16'd0);
        // empty most of the table again
        repeat (50) send_req(ffba_pkg::OP_RELEASE, 16'd0, known_addr());
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_request = 1'b1;
        repeat (30) begin
            if ($urandom_range(0, 1))
                send_req(ffba_pkg::OP_ALLOC, 16'($urandom_range(1, 64)), 16'd0);
            else
                send_req(ffba_pkg::OP_RELEASE, 16'd0, known_addr());
        end
    endtask

    task automatic random_item();
        int pick;
        logic [15:0] size;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            size = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
            send_req(ffba_pkg::OP_ALLOC, size, 16'($urandom));
        end else if (pick < 85) begin
            send_req(ffba_pkg::OP_RELEASE, 16'($urandom), known_addr());
        end else if (pick < 92) begin
            send_req(ffba_pkg::OP_RELEASE, 16'($urandom), 16'($urandom));
        end else if (pick < 96) begin
            send_req(ffba_pkg::OP_ALLOC, 16'd0, 16'($urandom));
        end else begin
            send_req(ffba_pkg::OP_RELEASE, 16'($urandom), 16'd0);
        end
    endtask

    task automatic test_random();
        write_limit(17'($urandom_range(4000, 20000)));
        repeat (200) random_item();
        write_limit(17'h1FFFF);
        repeat (180) random_item();
        wait_drained();
        idling_on = 1'b0;
        repeat (150) random_item();
    endtask

    // main sequence
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        req.valid    = 1'b0;
        req.op       = ffba_pkg::OP_ALLOC;
        req.size     = '0;
        req.addr     = '0;
        mismatches   = 0;
        idle_cycles  = 0;
        idling_on    = 1'b1;
        hold_request = 1'b0;
        blk_count    = 0;
        arena_top    = 0;
        arena_limit  = int'(ffba_pkg::LIMIT_RST);
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_limits();
        test_table_full();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/ffba_pkg.sv
sv/ffba_if.sv
sv/ffba_dpath.sv
sv/ffba_ctrl.sv
sv/first_fit_block_allocator.sv
sv/ffba_chk.sv
tb/tb_top.sv
